// ===== rtl/core/e2g_pkg.sv =====
// shared types, constants and tables of the ecef to geodetic core
package e2g_pkg;

    localparam int GUARD_BITS   = 16;
    localparam int CORDIC_LAST  = 30;
    localparam int DIV_LAST     = 63;
    localparam int SQRT_LAST    = 31;
    localparam int MAX_PASSES   = 16;

    localparam logic [30:0] KINV_Q31    = 31'd1304065748;
    localparam logic [22:0] EQ_RADIUS_M = 23'd6378137;
    localparam logic [32:0] E2_WGS84    = 33'd7360548640;
    localparam logic [32:0] E2_CGCS2000 = 33'd7360548676;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_CORDIC_XY,
        OP_CORDIC_RZ,
        OP_PASS_BEGIN,
        OP_CORDIC_STEP,
        OP_GAIN_HI,
        OP_GAIN_LO,
        OP_GAIN_END_R,
        OP_GAIN_END_M,
        OP_SET_NC,
        OP_SIN_PREP,
        OP_NORM_STEP,
        OP_DIV_START_S,
        OP_DIV_STEP,
        OP_SET_S,
        OP_MUL_SS,
        OP_SET_S2,
        OP_MUL_E2S2,
        OP_SET_W,
        OP_SQRT_STEP,
        OP_DIV_START_INV,
        OP_MUL_AINV,
        OP_SET_V,
        OP_MUL_E2S,
        OP_SET_E2S,
        OP_MUL_VHI,
        OP_MUL_VLO,
        OP_SET_Z,
        OP_FINISH
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic axis;
        logic step_last;
        logic z_moving;
        logic pass_cap;
        logic norm_big;
    } dp_status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_START,
        S_LOOP,
        S_FLOAD,
        S_CSTEP,
        S_GHI,
        S_GLO,
        S_GEND,
        S_SPREP,
        S_NORM,
        S_DIVS,
        S_SETS,
        S_MSS,
        S_S2,
        S_ME2S2,
        S_SETW,
        S_SQRT,
        S_DIVI0,
        S_DIVI,
        S_MAINV,
        S_SETV,
        S_ME2S,
        S_SETE2S,
        S_MVHI,
        S_MVLO,
        S_SETZ,
        S_FINISH
    } ctrl_state_t;

    typedef enum logic [1:0] {
        PH_LON,
        PH_PASS,
        PH_FINAL
    } cordic_phase_t;

    function automatic logic [29:0] atan_entry(input logic [4:0] idx);
        logic [29:0] val;
        case (idx)
            5'd0:  val = 30'd536870912;
            5'd1:  val = 30'd316933406;
            5'd2:  val = 30'd167458907;
            5'd3:  val = 30'd85004756;
            5'd4:  val = 30'd42667331;
            5'd5:  val = 30'd21354465;
            5'd6:  val = 30'd10679838;
            5'd7:  val = 30'd5340245;
            5'd8:  val = 30'd2670163;
            5'd9:  val = 30'd1335087;
            5'd10: val = 30'd667544;
            5'd11: val = 30'd333772;
            5'd12: val = 30'd166886;
            5'd13: val = 30'd83443;
            5'd14: val = 30'd41722;
            5'd15: val = 30'd20861;
            5'd16: val = 30'd10430;
            5'd17: val = 30'd5215;
            5'd18: val = 30'd2608;
            5'd19: val = 30'd1304;
            5'd20: val = 30'd652;
            5'd21: val = 30'd326;
            5'd22: val = 30'd163;
            5'd23: val = 30'd81;
            5'd24: val = 30'd41;
            5'd25: val = 30'd20;
            5'd26: val = 30'd10;
            5'd27: val = 30'd5;
            5'd28: val = 30'd3;
            5'd29: val = 30'd1;
            5'd30: val = 30'd1;
            default: val = 30'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/e2g_in_if.sv =====
// request channel carrying one ecef position
interface e2g_in_if;
    logic               valid;
    logic               ready;
    logic signed [39:0] ecef_x;
    logic signed [39:0] ecef_y;
    logic signed [39:0] ecef_z;

    modport source (output valid, output ecef_x, output ecef_y, output ecef_z, input ready);
    modport sink (input valid, input ecef_x, input ecef_y, input ecef_z, output ready);
endinterface

// ===== rtl/core/e2g_out_if.sv =====
// result channel carrying one geodetic position
interface e2g_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] latitude;
    logic signed [31:0] longitude;
    logic signed [39:0] height;
    logic               not_converged;

    modport source (output valid, output latitude, output longitude, output height,
                    output not_converged, input ready);
    modport sink (input valid, input latitude, input longitude, input height,
                  input not_converged, output ready);
endinterface

// ===== rtl/core/e2g_ctrl.sv =====
// sequencer that steps the datapath through one conversion
module e2g_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  e2g_pkg::dp_status_t  status,
    output e2g_pkg::dp_cmd_t     cmd
);

    e2g_pkg::ctrl_state_t   state_reg, state_next;
    e2g_pkg::cordic_phase_t phase_reg, phase_next;
    logic                   out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= e2g_pkg::S_IDLE;
            phase_reg     <= e2g_pkg::PH_LON;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd.op         = e2g_pkg::OP_NONE;
        in_ready       = 1'b0;
        case (state_reg)
            e2g_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = e2g_pkg::OP_LOAD;
                    state_next = e2g_pkg::S_START;
                end
            end
            e2g_pkg::S_START:
            begin
                if (status.axis)
                begin
                    state_next = e2g_pkg::S_LOOP;
                end
                else
                begin
                    cmd.op     = e2g_pkg::OP_CORDIC_XY;
                    phase_next = e2g_pkg::PH_LON;
                    state_next = e2g_pkg::S_CSTEP;
                end
            end
            e2g_pkg::S_LOOP:
            begin
                if (!status.z_moving)
                begin
                    state_next = e2g_pkg::S_FLOAD;
                end
                else if (status.pass_cap)
                begin
                    cmd.op     = e2g_pkg::OP_SET_NC;
                    state_next = e2g_pkg::S_FLOAD;
                end
                else
                begin
                    cmd.op     = e2g_pkg::OP_PASS_BEGIN;
                    phase_next = e2g_pkg::PH_PASS;
                    state_next = e2g_pkg::S_CSTEP;
                end
            end
            e2g_pkg::S_FLOAD:
            begin
                cmd.op     = e2g_pkg::OP_CORDIC_RZ;
                phase_next = e2g_pkg::PH_FINAL;
                state_next = e2g_pkg::S_CSTEP;
            end
            e2g_pkg::S_CSTEP:
            begin
                cmd.op = e2g_pkg::OP_CORDIC_STEP;
                if (status.step_last)
                begin
                    state_next = e2g_pkg::S_GHI;
                end
            end
            e2g_pkg::S_GHI:
            begin
                cmd.op     = e2g_pkg::OP_GAIN_HI;
                state_next = e2g_pkg::S_GLO;
            end
            e2g_pkg::S_GLO:
            begin
                cmd.op     = e2g_pkg::OP_GAIN_LO;
                state_next = e2g_pkg::S_GEND;
            end
            e2g_pkg::S_GEND:
            begin
                case (phase_reg)
                    e2g_pkg::PH_LON:
                    begin
                        cmd.op     = e2g_pkg::OP_GAIN_END_R;
                        state_next = e2g_pkg::S_LOOP;
                    end
                    e2g_pkg::PH_PASS:
                    begin
                        cmd.op     = e2g_pkg::OP_GAIN_END_M;
                        state_next = e2g_pkg::S_SPREP;
                    end
                    default:
                    begin
                        cmd.op     = e2g_pkg::OP_GAIN_END_M;
                        state_next = e2g_pkg::S_FINISH;
                    end
                endcase
            end
            e2g_pkg::S_SPREP:
            begin
                cmd.op     = e2g_pkg::OP_SIN_PREP;
                state_next = e2g_pkg::S_NORM;
            end
            e2g_pkg::S_NORM:
            begin
                if (status.norm_big)
                begin
                    cmd.op = e2g_pkg::OP_NORM_STEP;
                end
                else
                begin
                    cmd.op     = e2g_pkg::OP_DIV_START_S;
                    state_next = e2g_pkg::S_DIVS;
                end
            end
            e2g_pkg::S_DIVS:
            begin
                cmd.op = e2g_pkg::OP_DIV_STEP;
                if (status.step_last)
                begin
                    state_next = e2g_pkg::S_SETS;
                end
            end
            e2g_pkg::S_SETS:
            begin
                cmd.op     = e2g_pkg::OP_SET_S;
                state_next = e2g_pkg::S_MSS;
            end
            e2g_pkg::S_MSS:
            begin
                cmd.op     = e2g_pkg::OP_MUL_SS;
                state_next = e2g_pkg::S_S2;
            end
            e2g_pkg::S_S2:
            begin
                cmd.op     = e2g_pkg::OP_SET_S2;
                state_next = e2g_pkg::S_ME2S2;
            end
            e2g_pkg::S_ME2S2:
            begin
                cmd.op     = e2g_pkg::OP_MUL_E2S2;
                state_next = e2g_pkg::S_SETW;
            end
            e2g_pkg::S_SETW:
            begin
                cmd.op     = e2g_pkg::OP_SET_W;
                state_next = e2g_pkg::S_SQRT;
            end
            e2g_pkg::S_SQRT:
            begin
                cmd.op = e2g_pkg::OP_SQRT_STEP;
                if (status.step_last)
                begin
                    state_next = e2g_pkg::S_DIVI0;
                end
            end
            e2g_pkg::S_DIVI0:
            begin
                cmd.op     = e2g_pkg::OP_DIV_START_INV;
                state_next = e2g_pkg::S_DIVI;
            end
            e2g_pkg::S_DIVI:
            begin
                cmd.op = e2g_pkg::OP_DIV_STEP;
                if (status.step_last)
                begin
                    state_next = e2g_pkg::S_MAINV;
                end
            end
            e2g_pkg::S_MAINV:
            begin
                cmd.op     = e2g_pkg::OP_MUL_AINV;
                state_next = e2g_pkg::S_SETV;
            end
            e2g_pkg::S_SETV:
            begin
                cmd.op     = e2g_pkg::OP_SET_V;
                state_next = e2g_pkg::S_ME2S;
            end
            e2g_pkg::S_ME2S:
            begin
                cmd.op     = e2g_pkg::OP_MUL_E2S;
                state_next = e2g_pkg::S_SETE2S;
            end
            e2g_pkg::S_SETE2S:
            begin
                cmd.op     = e2g_pkg::OP_SET_E2S;
                state_next = e2g_pkg::S_MVHI;
            end
            e2g_pkg::S_MVHI:
            begin
                cmd.op     = e2g_pkg::OP_MUL_VHI;
                state_next = e2g_pkg::S_MVLO;
            end
            e2g_pkg::S_MVLO:
            begin
                cmd.op     = e2g_pkg::OP_MUL_VLO;
                state_next = e2g_pkg::S_SETZ;
            end
            e2g_pkg::S_SETZ:
            begin
                cmd.op     = e2g_pkg::OP_SET_Z;
                state_next = e2g_pkg::S_LOOP;
            end
            e2g_pkg::S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = e2g_pkg::OP_FINISH;
                    out_valid_next = 1'b1;
                    state_next     = e2g_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = e2g_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/e2g_dp.sv =====
// datapath: shared cordic, multiplier, divider and square root with result register
module e2g_dp #(
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic                clk,
    input  logic                rst_n,
    input  e2g_pkg::dp_cmd_t    cmd,
    output e2g_pkg::dp_status_t status,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    input  logic signed [39:0]  in_x,
    input  logic signed [39:0]  in_y,
    input  logic signed [39:0]  in_z,
    output logic signed [31:0]  lat,
    output logic signed [31:0]  lon,
    output logic signed [39:0]  hgt,
    output logic                nc_out
);

    localparam int VRND_SH = 29 - COORD_FRAC_BITS;
    localparam int V_SH    = 30 - COORD_FRAC_BITS;

    logic               datum_reg;
    logic signed [39:0] x_reg, y_reg, zin_reg, x_next, y_next, zin_next;
    logic signed [47:0] z_reg, zk_reg, z_next, zk_next;
    logic [39:0]        v_reg, v_next;
    logic [47:0]        r_reg, m_reg, r_next, m_next;
    logic signed [33:0] lon_reg, lon_next;
    logic               nc_reg, nc_next;
    logic [4:0]         pass_reg, pass_next;
    logic signed [63:0] cx_reg, cy_reg, cx_next, cy_next;
    logic signed [33:0] ca_reg, ca_next;
    logic [5:0]         step_reg, lim_reg, step_next, lim_next;
    logic [67:0]        prod_reg, acc_reg, acc_next;
    logic [47:0]        mn_reg, zn_reg, mn_next, zn_next;
    logic [63:0]        dq_reg, dq_next;
    logic [31:0]        drem_reg, dden_reg, drem_next, dden_next;
    logic [30:0]        s_reg, s2_reg, s_next, s2_next;
    logic [60:0]        sqn_reg, sqn_next;
    logic [63:0]        sqr_reg, sqr_next;
    logic [32:0]        e2s_reg, e2s_next;
    logic signed [31:0] lat_out_reg, lon_out_reg, lat_out_next, lon_out_next;
    logic signed [39:0] h_out_reg, h_out_next;
    logic               nc_out_reg, nc_out_next;

    logic [32:0]        e2;
    logic [33:0]        mul_a, mul_b;
    logic signed [63:0] ld_x, ld_y, pr_x, pr_y, dx, dy;
    logic signed [33:0] pr_a, tab;
    logic [4:0]         sh;
    logic [67:0]        gq, gr, wt, vs, zs;
    logic [47:0]        mag, az, dz;
    logic [32:0]        dsh;
    logic [63:0]        sbit, st;
    logic [31:0]        sqv;
    logic [30:0]        wv;
    logic signed [47:0] zin_ext;
    logic signed [33:0] la;
    logic signed [48:0] hd;

    assign e2      = datum_reg ? e2g_pkg::E2_CGCS2000 : e2g_pkg::E2_WGS84;
    assign sh      = step_reg[4:0];
    assign zin_ext = {{8{zin_reg[39]}}, zin_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            datum_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            datum_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        zin_reg     <= zin_next;
        z_reg       <= z_next;
        zk_reg      <= zk_next;
        v_reg       <= v_next;
        r_reg       <= r_next;
        m_reg       <= m_next;
        lon_reg     <= lon_next;
        nc_reg      <= nc_next;
        pass_reg    <= pass_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        ca_reg      <= ca_next;
        step_reg    <= step_next;
        lim_reg     <= lim_next;
        prod_reg    <= mul_a * mul_b;
        acc_reg     <= acc_next;
        mn_reg      <= mn_next;
        zn_reg      <= zn_next;
        dq_reg      <= dq_next;
        drem_reg    <= drem_next;
        dden_reg    <= dden_next;
        s_reg       <= s_next;
        s2_reg      <= s2_next;
        sqn_reg     <= sqn_next;
        sqr_reg     <= sqr_next;
        e2s_reg     <= e2s_next;
        lat_out_reg <= lat_out_next;
        lon_out_reg <= lon_out_next;
        h_out_reg   <= h_out_next;
        nc_out_reg  <= nc_out_next;
    end

    // cordic start vector and quarter turn pre-rotation
    always_comb
    begin
        if (cmd.op == e2g_pkg::OP_CORDIC_XY)
        begin
            ld_x = $signed({{24{x_reg[39]}}, x_reg}) <<< e2g_pkg::GUARD_BITS;
            ld_y = $signed({{24{y_reg[39]}}, y_reg}) <<< e2g_pkg::GUARD_BITS;
        end
        else
        begin
            ld_x = $signed({16'd0, r_reg}) <<< e2g_pkg::GUARD_BITS;
            ld_y = $signed({{16{z_reg[47]}}, z_reg}) <<< e2g_pkg::GUARD_BITS;
        end
        if (ld_x < 0)
        begin
            if (ld_y >= 0)
            begin
                pr_x = ld_y;
                pr_y = -ld_x;
                pr_a = e2g_pkg::QUARTER_TURN;
            end
            else
            begin
                pr_x = -ld_y;
                pr_y = ld_x;
                pr_a = -e2g_pkg::QUARTER_TURN;
            end
        end
        else
        begin
            pr_x = ld_x;
            pr_y = ld_y;
            pr_a = '0;
        end
    end

    always_comb
    begin
        dx   = cy_reg >>> sh;
        dy   = cx_reg >>> sh;
        tab  = $signed({4'd0, e2g_pkg::atan_entry(sh)});
        gq   = acc_reg + (prod_reg >> 31);
        gr   = gq + 68'd32768;
        mag  = gr[63:16];
        az   = z_reg[47] ? 48'(-z_reg) : 48'(z_reg);
        dsh  = {drem_reg, dq_reg[63]};
        sbit = 64'd1 << {(5'd31 - sh), 1'b0};
        st   = sqr_reg + sbit;
        sqv  = (sqr_reg == 64'd0) ? 32'd1 : sqr_reg[31:0];
        wt   = prod_reg + (68'd1 << 39);
        wv   = 31'd1073741824 - 31'(wt >> 40);
        vs   = prod_reg + (68'd1 << VRND_SH);
        zs   = acc_reg + (prod_reg >> 30) + 68'd512;
        dz   = 48'(zs >> 10);
        if (status.axis)
        begin
            la = (zin_reg > 0) ? e2g_pkg::QUARTER_TURN : -e2g_pkg::QUARTER_TURN;
        end
        else if (ca_reg > e2g_pkg::QUARTER_TURN)
        begin
            la = e2g_pkg::QUARTER_TURN;
        end
        else if (ca_reg < -e2g_pkg::QUARTER_TURN)
        begin
            la = -e2g_pkg::QUARTER_TURN;
        end
        else
        begin
            la = ca_reg;
        end
        hd = $signed({1'b0, m_reg}) - $signed({9'd0, v_reg});
    end

    always_comb
    begin
        x_next       = x_reg;
        y_next       = y_reg;
        zin_next     = zin_reg;
        z_next       = z_reg;
        zk_next      = zk_reg;
        v_next       = v_reg;
        r_next       = r_reg;
        m_next       = m_reg;
        lon_next     = lon_reg;
        nc_next      = nc_reg;
        pass_next    = pass_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        ca_next      = ca_reg;
        step_next    = step_reg;
        lim_next     = lim_reg;
        acc_next     = acc_reg;
        mn_next      = mn_reg;
        zn_next      = zn_reg;
        dq_next      = dq_reg;
        drem_next    = drem_reg;
        dden_next    = dden_reg;
        s_next       = s_reg;
        s2_next      = s2_reg;
        sqn_next     = sqn_reg;
        sqr_next     = sqr_reg;
        e2s_next     = e2s_reg;
        lat_out_next = lat_out_reg;
        lon_out_next = lon_out_reg;
        h_out_next   = h_out_reg;
        nc_out_next  = nc_out_reg;
        mul_a        = '0;
        mul_b        = '0;
        case (cmd.op)
            e2g_pkg::OP_LOAD:
            begin
                x_next    = in_x;
                y_next    = in_y;
                zin_next  = in_z;
                z_next    = {{8{in_z[39]}}, in_z};
                zk_next   = '0;
                v_next    = 40'(e2g_pkg::EQ_RADIUS_M) << COORD_FRAC_BITS;
                r_next    = '0;
                lon_next  = '0;
                nc_next   = 1'b0;
                pass_next = '0;
            end
            e2g_pkg::OP_CORDIC_XY, e2g_pkg::OP_CORDIC_RZ:
            begin
                cx_next   = pr_x;
                cy_next   = pr_y;
                ca_next   = pr_a;
                step_next = '0;
                lim_next  = 6'(e2g_pkg::CORDIC_LAST);
            end
            e2g_pkg::OP_PASS_BEGIN:
            begin
                zk_next   = z_reg;
                pass_next = pass_reg + 5'd1;
                cx_next   = pr_x;
                cy_next   = pr_y;
                ca_next   = pr_a;
                step_next = '0;
                lim_next  = 6'(e2g_pkg::CORDIC_LAST);
            end
            e2g_pkg::OP_CORDIC_STEP:
            begin
                step_next = step_reg + 6'd1;
                if (cy_reg >= 0)
                begin
                    cx_next = cx_reg + dx;
                    cy_next = cy_reg - dy;
                    ca_next = ca_reg + tab;
                end
                else
                begin
                    cx_next = cx_reg - dx;
                    cy_next = cy_reg + dy;
                    ca_next = ca_reg - tab;
                end
            end
            e2g_pkg::OP_GAIN_HI:
            begin
                mul_a = {1'b0, cx_reg[63:31]};
                mul_b = {3'd0, e2g_pkg::KINV_Q31};
            end
            e2g_pkg::OP_GAIN_LO:
            begin
                acc_next = prod_reg;
                mul_a    = {3'd0, cx_reg[30:0]};
                mul_b    = {3'd0, e2g_pkg::KINV_Q31};
            end
            e2g_pkg::OP_GAIN_END_R:
            begin
                r_next   = mag;
                lon_next = ca_reg;
            end
            e2g_pkg::OP_GAIN_END_M:
            begin
                m_next = mag;
            end
            e2g_pkg::OP_SET_NC:
            begin
                nc_next = 1'b1;
            end
            e2g_pkg::OP_SIN_PREP:
            begin
                mn_next = m_reg;
                zn_next = (az > m_reg) ? m_reg : az;
            end
            e2g_pkg::OP_NORM_STEP:
            begin
                mn_next = mn_reg >> 1;
                zn_next = zn_reg >> 1;
            end
            e2g_pkg::OP_DIV_START_S:
            begin
                dq_next   = ({32'd0, zn_reg[31:0]} << 30) + {33'd0, mn_reg[31:1]};
                dden_next = mn_reg[31:0];
                drem_next = '0;
                step_next = '0;
                lim_next  = 6'(e2g_pkg::DIV_LAST);
            end
            e2g_pkg::OP_DIV_START_INV:
            begin
                dq_next   = (64'd1 << 60) + {33'd0, sqv[31:1]};
                dden_next = sqv;
                drem_next = '0;
                step_next = '0;
                lim_next  = 6'(e2g_pkg::DIV_LAST);
            end
            e2g_pkg::OP_DIV_STEP:
            begin
                step_next = step_reg + 6'd1;
                if (dsh >= {1'b0, dden_reg})
                begin
                    drem_next = 32'(dsh - {1'b0, dden_reg});
                    dq_next   = {dq_reg[62:0], 1'b1};
                end
                else
                begin
                    drem_next = dsh[31:0];
                    dq_next   = {dq_reg[62:0], 1'b0};
                end
            end
            e2g_pkg::OP_SET_S:
            begin
                if (mn_reg == '0)
                begin
                    s_next = '0;
                end
                else if (dq_reg > 64'd1073741824)
                begin
                    s_next = 31'd1073741824;
                end
                else
                begin
                    s_next = dq_reg[30:0];
                end
            end
            e2g_pkg::OP_MUL_SS:
            begin
                mul_a = {3'd0, s_reg};
                mul_b = {3'd0, s_reg};
            end
            e2g_pkg::OP_SET_S2:
            begin
                s2_next = 31'((prod_reg + (68'd1 << 29)) >> 30);
            end
            e2g_pkg::OP_MUL_E2S2:
            begin
                mul_a = {1'b0, e2};
                mul_b = {3'd0, s2_reg};
            end
            e2g_pkg::OP_SET_W:
            begin
                sqn_next  = {wv, 30'd0};
                sqr_next  = '0;
                step_next = '0;
                lim_next  = 6'(e2g_pkg::SQRT_LAST);
            end
            e2g_pkg::OP_SQRT_STEP:
            begin
                step_next = step_reg + 6'd1;
                if ({3'd0, sqn_reg} >= st)
                begin
                    sqn_next = sqn_reg - st[60:0];
                    sqr_next = (sqr_reg >> 1) + sbit;
                end
                else
                begin
                    sqr_next = sqr_reg >> 1;
                end
            end
            e2g_pkg::OP_MUL_AINV:
            begin
                mul_a = {11'd0, e2g_pkg::EQ_RADIUS_M};
                mul_b = dq_reg[33:0];
            end
            e2g_pkg::OP_SET_V:
            begin
                v_next = 40'(vs >> V_SH);
            end
            e2g_pkg::OP_MUL_E2S:
            begin
                mul_a = {1'b0, e2};
                mul_b = {3'd0, s_reg};
            end
            e2g_pkg::OP_SET_E2S:
            begin
                e2s_next = prod_reg[62:30];
            end
            e2g_pkg::OP_MUL_VHI:
            begin
                mul_a = {24'd0, v_reg[39:30]};
                mul_b = {1'b0, e2s_reg};
            end
            e2g_pkg::OP_MUL_VLO:
            begin
                acc_next = prod_reg;
                mul_a    = {4'd0, v_reg[29:0]};
                mul_b    = {1'b0, e2s_reg};
            end
            e2g_pkg::OP_SET_Z:
            begin
                z_next = z_reg[47] ? (zin_ext - $signed(dz)) : (zin_ext + $signed(dz));
            end
            e2g_pkg::OP_FINISH:
            begin
                lat_out_next = la[31:0];
                lon_out_next = lon_reg[31:0];
                nc_out_next  = nc_reg;
                if (hd > 49'sd549755813887)
                begin
                    h_out_next = 40'sh7FFFFFFFFF;
                end
                else if (hd < -49'sd549755813888)
                begin
                    h_out_next = 40'sh8000000000;
                end
                else
                begin
                    h_out_next = hd[39:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    assign status.axis      = (x_reg == '0) && (y_reg == '0);
    assign status.step_last = (step_reg == lim_reg);
    assign status.z_moving  = (z_reg != zk_reg);
    assign status.pass_cap  = (pass_reg == 5'(e2g_pkg::MAX_PASSES));
    assign status.norm_big  = |mn_reg[47:32];

    assign lat    = lat_out_reg;
    assign lon    = lon_out_reg;
    assign hgt    = h_out_reg;
    assign nc_out = nc_out_reg;

endmodule

// ===== rtl/core/ecef_to_geodetic_core.sv =====
// top level of the ecef to geodetic converter
// usage:
// - pos carries one earth-centred x, y, z request (valid/ready); it is taken
//   only when the core is idle, one request at a time
// - geo returns latitude, longitude, height and the not_converged flag; the
//   result sits in an output register until geo.ready, and a new request may
//   be taken meanwhile
// - cfg_we/cfg_wdata write the datum select bit (0 wgs84, 1 cgcs2000) while idle;
//   the user is bound to this, and the core itself does not enforce it
// - each refinement pass makes n (0 to 16) normalize shifts before the sine
//   divide; at most 16 passes
// - each pass runs a 31-step cordic, two bit-serial divides and a bit-serial
//   square root; its products share one 34x34 multiplier
// - one request in flight: a new request is taken only when the core is idle
// - reset clears the sequencer, the output valid and the datum select bit
// - a stalled receiver holds the result; a finished conversion waits until
//   the output register is free
module ecef_to_geodetic_core #(
    parameter int COORD_FRAC_BITS = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    e2g_in_if.sink     pos,
    e2g_out_if.source  geo,
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    e2g_pkg::dp_cmd_t    cmd;
    e2g_pkg::dp_status_t status;

    e2g_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pos.valid),
        .in_ready  (pos.ready),
        .out_valid (geo.valid),
        .out_ready (geo.ready),
        .status    (status),
        .cmd       (cmd)
    );

    e2g_dp #(
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_x      (pos.ecef_x),
        .in_y      (pos.ecef_y),
        .in_z      (pos.ecef_z),
        .lat       (geo.latitude),
        .lon       (geo.longitude),
        .hgt       (geo.height),
        .nc_out    (geo.not_converged)
    );

`ifndef SYNTHESIS
    a_lat_range: assert property (@(posedge clk) disable iff (!rst_n)
        geo.valid |-> (geo.latitude <= 32'sd1073741824 && geo.latitude >= -32'sd1073741824))
        else $error("latitude out of range");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        pos.valid && pos.ready |=> !pos.ready)
        else $error("request taken while busy");

    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(geo.valid) |-> $past(geo.ready))
        else $error("result dropped without handshake");
`endif

endmodule

// ===== test/ecef_to_geodetic_core_tb.sv =====
// self-checking testbench of the ecef to geodetic core with a bit-exact predictor
module ecef_to_geodetic_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  FRAC        = 10;
    localparam longint CYCLE_LIMIT = 12000000;
    localparam longint QTURN    = 64'sd1073741824;
    localparam longint unsigned KINV = 64'd1304065748;
    localparam longint unsigned RADIUS = 64'd6378137;

    typedef struct {
        logic signed [31:0] latitude;
        logic signed [31:0] longitude;
        logic signed [39:0] height;
        logic               not_converged;
    } geo_fix_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    e2g_in_if  pos_if();
    e2g_out_if geo_if();

    ecef_to_geodetic_core #(.COORD_FRAC_BITS(FRAC)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pos       (pos_if.sink),
        .geo       (geo_if.source),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    geo_fix_t fix_queue[$];
    bit       datum_model;
    bit       idle_on;
    int       errors;
    longint   cycles;
    int       stall_left;

    longint atan_rom[31] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1
    };

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    task automatic rotate_to_axis(input longint xi, input longint yi,
                                  output longint unsigned mag, output longint ang);
        longint x;
        longint y;
        longint a;
        longint t;
        longint dx;
        longint dy;
        longint unsigned ux;
        longint unsigned q;
        x = xi;
        y = yi;
        a = 0;
        if (x < 0)
        begin
            t = x;
            if (y >= 0)
            begin
                x = y;
                y = -t;
                a = QTURN;
            end
            else
            begin
                x = -y;
                y = t;
                a = -QTURN;
            end
        end
        for (int i = 0; i < 31; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0)
            begin
                x = x + dx;
                y = y - dy;
                a = a + atan_rom[i];
            end
            else
            begin
                x = x - dx;
                y = y + dy;
                a = a - atan_rom[i];
            end
        end
        ux = longint'(x);
        q = (ux >> 31) * KINV + (((ux & 64'h7FFFFFFF) * KINV) >> 31);
        mag = (q + (64'd1 << 15)) >> 16;
        ang = a;
    endtask

    task automatic predict_fix(input logic signed [39:0] px, input logic signed [39:0] py,
                               input logic signed [39:0] pz, output geo_fix_t fix);
        longint X, Y, Z, lon, lat, z, zk, h, unused;
        longint unsigned e2, r, m, v, az, s, s2, w, sq, inv, e2s, dz, mn, zn, prod;
        bit axis;
        int passes;
        int sh;
        X = px;
        Y = py;
        Z = pz;
        e2 = datum_model ? 64'(e2g_pkg::E2_CGCS2000) : 64'(e2g_pkg::E2_WGS84);
        axis = (X == 0) && (Y == 0);
        r = 0;
        lon = 0;
        fix.not_converged = 1'b0;
        if (!axis)
            rotate_to_axis(X * 65536, Y * 65536, r, lon);
        v = RADIUS << FRAC;
        z = Z;
        zk = 0;
        passes = 0;
        while (z != zk)
        begin
            if (passes == e2g_pkg::MAX_PASSES)
            begin
                fix.not_converged = 1'b1;
                break;
            end
            zk = z;
            rotate_to_axis(longint'(r) * 65536, z * 65536, m, unused);
            az = (z < 0) ? -z : z;
            if (az > m)
                az = m;
            s = 0;
            if (m != 0)
            begin
                sh = 0;
                while ((m >> sh) >= (64'd1 << 32))
                    sh++;
                mn = m >> sh;
                zn = az >> sh;
                if (mn != 0)
                    s = ((zn << 30) + mn / 2) / mn;
                if (s > (64'd1 << 30))
                    s = 64'd1 << 30;
            end
            s2 = (s * s + (64'd1 << 29)) >> 30;
            w = (64'd1 << 30) - ((e2 * s2 + (64'd1 << 39)) >> 40);
            sq = int_sqrt(w << 30);
            if (sq == 0)
                sq = 1;
            inv = ((64'd1 << 60) + sq / 2) / sq;
            v = (RADIUS * inv + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
            e2s = (e2 * s) >> 30;
            prod = (v >> 30) * e2s + (((v & 64'h3FFFFFFF) * e2s) >> 30);
            dz = (prod + 512) >> 10;
            z = (z < 0) ? Z - longint'(dz) : Z + longint'(dz);
            passes++;
        end
        rotate_to_axis(longint'(r) * 65536, z * 65536, m, lat);
        if (axis)
            lat = (Z > 0) ? QTURN : -QTURN;
        if (lat > QTURN)
            lat = QTURN;
        if (lat < -QTURN)
            lat = -QTURN;
        h = longint'(m) - longint'(v);
        if (h > ((64'sd1 <<< 39) - 1))
            h = (64'sd1 <<< 39) - 1;
        if (h < -(64'sd1 <<< 39))
            h = -(64'sd1 <<< 39);
        fix.latitude = lat[31:0];
        fix.longitude = lon[31:0];
        fix.height = h[39:0];
    endtask

    task automatic send_pos(input logic signed [39:0] x, input logic signed [39:0] y,
                            input logic signed [39:0] z);
        geo_fix_t fix;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            pos_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        pos_if.valid <= 1'b1;
        pos_if.ecef_x <= x;
        pos_if.ecef_y <= y;
        pos_if.ecef_z <= z;
        do
            @(posedge clk);
        while (!pos_if.ready);
        predict_fix(x, y, z, fix);
        fix_queue.insert(fix_queue.size(), fix);
    endtask

    task automatic wait_drained();
        pos_if.valid <= 1'b0;
        @(posedge clk);
        while (fix_queue.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic set_datum(input bit sel);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= sel;
        @(posedge clk);
        cfg_we <= 1'b0;
        datum_model = sel;
    endtask

    function automatic logic signed [39:0] any_coord();
        return 40'({$urandom, $urandom});
    endfunction

    function automatic logic signed [39:0] earth_coord();
        logic [33:0] t;
        t = {2'($urandom_range(0, 3)), $urandom};
        return 40'(signed'({6'd0, t}) - 40'sd8589934592);
    endfunction

    function automatic logic signed [39:0] pick_coord();
        int k;
        k = $urandom_range(0, 9);
        if (k < 6)
            return earth_coord();
        else if (k < 8)
            return any_coord();
        else if (k < 9)
            return 40'sd0;
        else
            return 40'(signed'($urandom_range(0, 64)) - 40'sd32);
    endfunction

    task automatic test_directed();
        logic signed [39:0] mx, mn;
        mx = 40'sh7FFFFFFFFF;
        mn = -40'sh8000000000;
        send_pos(40'sd0, 40'sd0, 40'sd0);
        send_pos(40'sd0, 40'sd0, 40'sd6535000000);
        send_pos(40'sd0, 40'sd0, -40'sd6535000000);
        send_pos(40'sd0, 40'sd0, mx);
        send_pos(40'sd0, 40'sd0, mn);
        send_pos(40'sd6531000000, 40'sd0, 40'sd0);
        send_pos(-40'sd6531000000, 40'sd0, 40'sd0);
        send_pos(-40'sd6531000000, 40'sd1, 40'sd1000);
        send_pos(-40'sd6531000000, -40'sd1, -40'sd1000);
        send_pos(40'sd0, 40'sd6531000000, 40'sd100);
        send_pos(40'sd0, -40'sd6531000000, -40'sd100);
        send_pos(mx, mx, mx);
        send_pos(mn, mn, mn);
        send_pos(mx, mn, 40'sd0);
        send_pos(mn, mx, mx);
        send_pos(40'sd1, 40'sd1, mx);
        send_pos(40'sd1, 40'sd0, mn);
        send_pos(40'sd4500000000, 40'sd500000000, 40'sd4400000000);
        send_pos(-40'sd1, -40'sd1, -40'sd1);
        send_pos(40'sd1, 40'sd0, 40'sd1);
    endtask

    task automatic test_random(input int count);
        for (int i = 0; i < count; i++)
            send_pos(pick_coord(), pick_coord(), pick_coord());
    endtask

    task automatic test_datum_switch();
        set_datum(1'b1);
        test_directed();
        test_random(150);
        set_datum(1'b0);
        test_random(150);
    endtask

    task automatic test_drain_pause();
        test_random(20);
        wait_drained();
        test_random(150);
    endtask

    task automatic test_tail_no_idle();
        set_datum(1'b1);
        idle_on = 1'b0;
        test_random(150);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        int n;
        if (!rst_n)
        begin
            geo_if.ready <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            n = stall_left;
            if (n > 0)
                n = n - 1;
            else if (idle_on && $urandom_range(0, 5) == 0)
                n = $urandom_range(1, 15);
            stall_left <= n;
            geo_if.ready <= (n == 0);
        end
    end

    always @(posedge clk)
    begin
        geo_fix_t want;
        if (rst_n && geo_if.valid && geo_if.ready)
        begin
            if (fix_queue.size() == 0)
            begin
                $display("%0t unexpected result lat %h lon %h h %h nc %b", $time,
                         geo_if.latitude, geo_if.longitude, geo_if.height,
                         geo_if.not_converged);
                errors++;
            end
            else
            begin
                want = fix_queue.pop_front();
                if (geo_if.latitude !== want.latitude)
                begin
                    $display("%0t latitude expected %h actual %h", $time,
                             want.latitude, geo_if.latitude);
                    errors++;
                end
                if (geo_if.longitude !== want.longitude)
                begin
                    $display("%0t longitude expected %h actual %h", $time,
                             want.longitude, geo_if.longitude);
                    errors++;
                end
                if (geo_if.height !== want.height)
                begin
                    $display("%0t height expected %h actual %h", $time,
                             want.height, geo_if.height);
                    errors++;
                end
                if (geo_if.not_converged !== want.not_converged)
                begin
                    $display("%0t not_converged expected %b actual %b", $time,
                             want.not_converged, geo_if.not_converged);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        errors = 0;
        cycles = 0;
        datum_model = 1'b0;
        idle_on = 1'b1;
        rst_n = 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 1'b0;
        pos_if.valid <= 1'b0;
        pos_if.ecef_x <= '0;
        pos_if.ecef_y <= '0;
        pos_if.ecef_z <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        set_datum(1'b0);
        test_random(150);
        test_datum_switch();
        test_drain_pause();
        test_tail_no_idle();
        wait_drained();
        repeat (4000) @(posedge clk);
        if (errors == 0 && fix_queue.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule
